// ===== hdl/keyboard_walk_detector_core_defines.svh =====
// Assertion macros for the keyboard walk detector top level.
`ifndef KEYBOARD_WALK_DETECTOR_CORE_DEFINES_SVH
`define KEYBOARD_WALK_DETECTOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define KWD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define KWD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KWD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define KWD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/kwd_pkg.sv =====
// Types, constants and key position tables for the keyboard walk detector.
package kwd_pkg;

  localparam int NUM_LAYOUTS  = 5;
  localparam int MAX_LEN      = 256;
  localparam int CHECK_WINDOW = 255;
  localparam int WALK_LIMIT   = 16;
  localparam int MIN_RUN      = 4;
  localparam int ROW_CHARS    = 13;
  localparam int NUM_BAD      = 6;

  // Four-letter words that reject a run, compared after lower-casing.
  localparam logic [31:0] BAD_WORDS [NUM_BAD] = '{"drew", "kiki", "fred", "were", "123;", "234;"};
  localparam logic [23:0] WORD_POP = "pop";

  // Position of one character on one layout.
  typedef struct packed {
    logic       hit;
    logic [1:0] row;
    logic [3:0] col;
  } key_pos_t;

  typedef key_pos_t [NUM_LAYOUTS-1:0] key_entry_t;
  typedef key_entry_t [127:0] key_rom_t;

  // Per-string tracking state.
  typedef struct packed {
    logic [7:0]  previous_char;
    logic [4:0]  active_layouts;
    logic [7:0]  run_start;
    logic [8:0]  run_length;
    logic [4:0]  walks_found;
    logic [7:0]  position;
    logic [23:0] run_head;
    logic [31:0] run_tail;
    logic [23:0] recent_lowered;
    logic        false_word_seen;
    logic [2:0]  class_flags;
  } kwd_state_t;

  // Result of one processed item.
  typedef struct packed {
    logic       has_result;
    logic       found;
    logic [7:0] start;
    logic [8:0] length;
    logic       done;
    logic [4:0] count;
  } kwd_result_t;

  // Enter one row legend into the table; later entries override earlier ones.
  function automatic key_rom_t add_row(key_rom_t rom, int lay, logic [1:0] row,
                                       logic [8*ROW_CHARS-1:0] s);
    key_rom_t   r;
    int         len;
    logic [7:0] ch;
    r   = rom;
    len = 0;
    for (int i = 0; i < ROW_CHARS; i++) begin
      if (s[8*i +: 8] != 8'h00) len++;
    end
    for (int i = 0; i < ROW_CHARS; i++) begin
      if (i < len) begin
        ch = s[8*(len-1-i) +: 8];
        if (!ch[7]) begin
          r[ch[6:0]][lay].hit = 1'b1;
          r[ch[6:0]][lay].row = row;
          r[ch[6:0]][lay].col = 4'(i);
        end
      end
    end
    return r;
  endfunction

  // Build the table for all five layouts, rows and shift levels in order.
  function automatic key_rom_t build_key_rom();
    key_rom_t r;
    r = '0;
    // QWERTY
    r = add_row(r, 0, 2'd0, "1234567890-=");
    r = add_row(r, 0, 2'd0, "!@#$%^&*()_+");
    r = add_row(r, 0, 2'd1, "qwertyuiop[]\\");
    r = add_row(r, 0, 2'd1, "QWERTYUIOP{}|");
    r = add_row(r, 0, 2'd2, "asdfghjkl;'");
    r = add_row(r, 0, 2'd2, "ASDFGHJKL:\"");
    r = add_row(r, 0, 2'd3, "zxcvbnm,./");
    r = add_row(r, 0, 2'd3, "ZXCVBNM<>?");
    // JCUKEN number row
    r = add_row(r, 1, 2'd0, "1234567890-=");
    r = add_row(r, 1, 2'd0, {"!\"", 8'h80, ";%:?*()_+"});
    // QWERTZ
    r = add_row(r, 2, 2'd0, "1234567890");
    r = add_row(r, 2, 2'd0, {"!\"", 8'h80, "$%&/()=?"});
    r = add_row(r, 2, 2'd1, "qwertzuiop");
    r = add_row(r, 2, 2'd1, "QWERTZUIOP");
    r = add_row(r, 2, 2'd2, "asdfghjkl");
    r = add_row(r, 2, 2'd2, "ASDFGHJKL");
    r = add_row(r, 2, 2'd3, "yxcvbnm,.-");
    r = add_row(r, 2, 2'd3, "YXCVBNM;:_");
    // AZERTY
    r = add_row(r, 3, 2'd0, "1234567890");
    r = add_row(r, 3, 2'd1, "azertyuiop");
    r = add_row(r, 3, 2'd1, "AZERTYUIOP");
    r = add_row(r, 3, 2'd2, "qsdfghjklm");
    r = add_row(r, 3, 2'd2, "QSDFGHJKLM");
    r = add_row(r, 3, 2'd3, "wxcvbn,;:!");
    r = add_row(r, 3, 2'd3, "WXCVBN?./");
    // Dvorak
    r = add_row(r, 4, 2'd0, "1234567890[]");
    r = add_row(r, 4, 2'd0, "!@#$%^&*(){}");
    r = add_row(r, 4, 2'd1, "',.pyfgcrl/=\\");
    r = add_row(r, 4, 2'd1, "\"<>PYFGCRL?+|");
    r = add_row(r, 4, 2'd2, "aoeuidhtns-");
    r = add_row(r, 4, 2'd2, "AOEUIDHTNS_");
    r = add_row(r, 4, 2'd3, ";qjkxbmwvz");
    r = add_row(r, 4, 2'd3, ":QJKXBMWVZ");
    return r;
  endfunction

  localparam key_rom_t KEY_ROM = build_key_rom();

endpackage

// ===== hdl/kwd_qualify.sv =====
// Decides whether a tracked run qualifies as a reportable walk.
module kwd_qualify import kwd_pkg::*; (
  input  kwd_state_t st,
  input  logic [4:0] limit,
  output logic       qualifies
);

  logic [7:0] h0, h1, h2, t0, t1, t2, t3;
  logic       two_classes;
  logic       head_bad, tail_bad;

  // Split the head and tail bytes of the checked window.
  assign h0 = st.run_head[7:0];
  assign h1 = st.run_head[15:8];
  assign h2 = st.run_head[23:16];
  assign t0 = st.run_tail[7:0];
  assign t1 = st.run_tail[15:8];
  assign t2 = st.run_tail[23:16];
  assign t3 = st.run_tail[31:24];

  // At least two of the alpha, digit and other classes were seen.
  assign two_classes = (st.class_flags[0] & st.class_flags[1]) |
                       (st.class_flags[0] & st.class_flags[2]) |
                       (st.class_flags[1] & st.class_flags[2]);

  // Case-sensitive start and end filters.
  assign head_bad = (h0 == "e") || (h0 == "y") || ((h1 == "e") && (h2 == "r")) ||
                    ((h0 == "t") && (h1 == "y")) ||
                    ((h0 == "1") && (h1 == "2") && (h2 == "3"));
  assign tail_bad = (t0 == "3") && (t1 == "2") && (t2 == "1") && (t3 != "q") && (t3 != "Q");

  assign qualifies = (st.run_length >= 9'(MIN_RUN)) && !head_bad && !tail_bad &&
                     !st.false_word_seen && two_classes && (st.walks_found < limit);

endmodule

// ===== hdl/kwd_step.sv =====
// Next-state and result logic for one character of the string.
module kwd_step import kwd_pkg::*; (
  input  logic [7:0]  char_code,
  input  logic        last,
  input  logic [4:0]  walk_quota,
  input  kwd_state_t  st,
  output kwd_state_t  st_next,
  output kwd_result_t res
);

  key_entry_t  ec, ep;
  logic [4:0]  present, adj, m;
  logic [7:0]  lc;
  logic [2:0]  cls;
  logic [4:0]  limit;
  logic        q_old, q_new, found1, found2;
  logic [8:0]  k;
  logic        in_window, pop_hit, word_hit;
  logic [31:0] word4;
  kwd_state_t  st_upd;

  // Key table lookups for the new and the previous character.
  always_comb begin
    ec = char_code[7] ? '0 : KEY_ROM[char_code[6:0]];
    ep = st.previous_char[7] ? '0 : KEY_ROM[st.previous_char[6:0]];
  end

  // Eight-neighbour adjacency on each layout.
  always_comb begin
    for (int l = 0; l < NUM_LAYOUTS; l++) begin
      present[l] = ec[l].hit;
      adj[l] = ec[l].hit && ep[l].hit &&
               (({1'b0, ec[l].row} == {1'b0, ep[l].row}) ||
                ({1'b0, ec[l].row} == {1'b0, ep[l].row} + 3'd1) ||
                ({1'b0, ep[l].row} == {1'b0, ec[l].row} + 3'd1)) &&
               (({1'b0, ec[l].col} == {1'b0, ep[l].col}) ||
                ({1'b0, ec[l].col} == {1'b0, ep[l].col} + 5'd1) ||
                ({1'b0, ep[l].col} == {1'b0, ec[l].col} + 5'd1)) &&
               !((ec[l].row == ep[l].row) && (ec[l].col == ep[l].col));
    end
  end
  assign m = st.active_layouts & adj;

  // Lower-cased byte and character class.
  always_comb begin
    lc = ((char_code >= "A") && (char_code <= "Z")) ? char_code + 8'd32 : char_code;
    if (((char_code >= "A") && (char_code <= "Z")) || ((char_code >= "a") && (char_code <= "z")))
      cls = 3'b001;
    else if ((char_code >= "0") && (char_code <= "9"))
      cls = 3'b010;
    else
      cls = 3'b100;
  end

  assign limit = (walk_quota > 5'(WALK_LIMIT)) ? 5'(WALK_LIMIT) : walk_quota;

  // False-word matches against the recent lower-cased bytes.
  assign k         = st.run_length;
  assign in_window = k < 9'(CHECK_WINDOW);
  assign word4     = {st.recent_lowered, lc};
  assign pop_hit   = (k >= 9'd2) && ({st.recent_lowered[15:0], lc} == WORD_POP);
  always_comb begin
    word_hit = 1'b0;
    for (int i = 0; i < NUM_BAD; i++) begin
      if (word4 == BAD_WORDS[i]) word_hit = 1'b1;
    end
    word_hit = word_hit && (k >= 9'd3);
  end

  kwd_qualify u_q_old (.st(st), .limit(limit), .qualifies(q_old));

  // Run tracking: start, extend or break.
  always_comb begin
    st_upd = st;
    found1 = 1'b0;
    if ((st.run_length != 9'd0) && (m != 5'd0)) begin
      st_upd.active_layouts = m;
      if (st.run_length < 9'(MAX_LEN)) begin
        if (in_window) begin
          if (k < 9'd3) st_upd.run_head[{k[1:0], 3'b000} +: 8] = char_code;
          st_upd.run_tail        = {st.run_tail[23:0], char_code};
          st_upd.recent_lowered  = {st.recent_lowered[15:0], lc};
          st_upd.false_word_seen = st.false_word_seen | pop_hit | word_hit;
          st_upd.class_flags     = st.class_flags | cls;
        end
        st_upd.run_length = st.run_length + 9'd1;
      end
    end else begin
      found1 = (st.run_length != 9'd0) && q_old;
      st_upd.walks_found     = st.walks_found + {4'd0, found1};
      st_upd.run_start       = st.position;
      st_upd.run_length      = 9'd1;
      st_upd.active_layouts  = present;
      st_upd.run_head        = {16'd0, char_code};
      st_upd.run_tail        = {24'd0, char_code};
      st_upd.recent_lowered  = {16'd0, lc};
      st_upd.false_word_seen = 1'b0;
      st_upd.class_flags     = cls;
    end
    st_upd.previous_char = char_code;
    st_upd.position      = st.position + 8'd1;
  end

  kwd_qualify u_q_new (.st(st_upd), .limit(limit), .qualifies(q_new));

  // On the last byte the open run is checked as well, then the string clears.
  assign found2  = last && !found1 && q_new;
  assign st_next = last ? '0 : st_upd;

  always_comb begin
    res.has_result = found1 | found2 | last;
    res.found      = found1 | found2;
    res.done       = last;
    res.count      = st_upd.walks_found + {4'd0, found2};
    if (found1) begin
      res.start  = st.run_start;
      res.length = st.run_length;
    end else if (found2) begin
      res.start  = st_upd.run_start;
      res.length = st_upd.run_length;
    end else begin
      res.start  = 8'd0;
      res.length = 9'd0;
    end
  end

endmodule

// ===== hdl/keyboard_walk_detector_core.sv =====
// Top level of the keyboard walk detector: item registers, state and result register.
//
// The input stream carries one password byte per item in s_tdata, with s_tlast
// on the final byte of a string. The block tracks runs of keys that are
// neighbours on one or more of five keyboard layouts and reports each
// qualifying run as one result item on the output stream; the item caused by
// the last byte always gives a result carrying the string's walk count.
// Bytes that finish no walk and are not last give no result.
// An accepted item is held in an input register, passes through the key table
// lookups and run filters combinationally and, if it gives a result, lands in the
// output register that drives m_tvalid. One item is taken every cycle unless a result
// waits on a full output; the per-string state feeds back through a single register.
// While the output register holds a result the receiver has not taken, items
// that give no result still move on; an item that gives one waits in the input
// register, and s_tready falls until the output frees. The user must write the walk
// quota register through cfg_we and cfg_wdata while idle; the block does not enforce it.
// Reset clears all string state, empties both registers and sets the quota to 16.
`include "keyboard_walk_detector_core_defines.svh"
module keyboard_walk_detector_core import kwd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] walk_start, [16:8] walk_length, [21:17] walk_count
  output logic        m_tuser,   // walk_found
  output logic        m_tlast    // done_res
);

  logic        quota_set;
  logic [4:0]  walk_quota;
  logic        in_valid;
  logic [7:0]  in_char;
  logic        in_last;
  logic        out_valid;
  logic        out_found;
  logic [7:0]  out_start;
  logic [8:0]  out_length;
  logic        out_done;
  logic [4:0]  out_count;
  logic        advance;
  kwd_state_t  state, state_next;
  kwd_result_t res;

  assign quota_set = walk_quota != 5'd0;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_quota <= 5'(WALK_LIMIT);
    end else if (cfg_we) begin
      walk_quota <= cfg_wdata;
    end
  end

  kwd_step u_step (
    .char_code  (in_char),
    .last       (in_last),
    .walk_quota (walk_quota),
    .st         (state),
    .st_next    (state_next),
    .res        (res)
  );

  // The held item moves on unless it has a result and the output is still full.
  assign advance  = in_valid && (!res.has_result || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input item register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata[7:0];
      in_last <= s_tlast;
    end
  end

  // Per-string state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.has_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.has_result) begin
      out_found  <= res.found;
      out_start  <= res.start;
      out_length <= res.length;
      out_done   <= res.done;
      out_count  <= res.count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_count, out_length, out_start};
  assign m_tuser  = out_found;
  assign m_tlast  = out_done;

  // Checks on the walk reporting logic.
  `KWD_ASSERT_SAME(a_count_limit, clk, rst, out_valid && quota_set, out_count <= walk_quota, "count above quota")
  `KWD_ASSERT_SAME(a_walk_min_len, clk, rst, out_valid && out_found, out_length >= 9'(MIN_RUN), "walk too short")
  `KWD_ASSERT_SAME(a_result_reason, clk, rst, out_valid, out_found || out_done, "result without reason")
  `KWD_ASSERT_NEXT(a_string_clear, clk, rst, advance && in_last, state.run_length == 9'd0, "state not cleared")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the keyboard walk detector core.
`timescale 1ns / 1ps

module testbench;

  localparam int LAYOUTS       = 5;
  localparam int RUN_CAP       = 256;
  localparam int WINDOW        = 255;
  localparam int LIMIT_CAP     = 16;
  localparam int MIN_WALK      = 4;
  localparam int ITEMS_PER_SET = 100;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 3000;

  // Key position of one character on one layout.
  typedef struct packed {
    bit       hit;
    bit [1:0] row;
    bit [3:0] col;
  } key_spot_t;

  // One password byte waiting to be sent.
  typedef struct packed {
    bit [7:0] code;
    bit       last;
  } key_item_t;

  // One walk report as the block should give it.
  typedef struct packed {
    bit       found;
    bit [7:0] start;
    bit [8:0] length;
    bit       done;
    bit [4:0] count;
  } walk_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] char_code
  logic        s_tlast = 1'b0; // last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [7:0] walk_start, [16:8] walk_length, [21:17] walk_count
  logic        m_tuser;        // walk_found
  logic        m_tlast;        // done_res

  // Key legends, indexed by 8 * layout + 2 * row + shift level.
  string        legend [40];
  key_spot_t    key_at [128][LAYOUTS];

  key_item_t    pending_items [$];
  walk_report_t walk_reports [$];
  bit [7:0]     draft [$];

  // Tracking state of the string in progress, as the block should hold it.
  bit [4:0]  walk_cap = 5'd16;
  bit [7:0]  prev_key;
  bit [4:0]  live_layouts;
  bit [7:0]  run_begin;
  bit [8:0]  run_len;
  bit [4:0]  walks_so_far;
  bit [7:0]  str_pos;
  bit [23:0] head_bytes;
  bit [31:0] tail_bytes;
  bit [23:0] lower_recent;
  bit        banned_word;
  bit [2:0]  char_classes;

  int        mismatches = 0;
  bit        sender_gaps_on = 1'b1;
  int        hold_requests = 0;
  bit [4:0]  cap_plan [8] = '{5'd0, 5'd1, 5'd16, 5'd2, 5'd15, 5'd4, 5'd3, 5'd16};

  keyboard_walk_detector_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #1 clk = ~clk;

  // Layouts on which a character has a key at all.
  function automatic bit [4:0] layouts_holding(bit [7:0] c);
    bit [4:0] m;
    m = '0;
    if (c < 128) begin
      for (int l = 0; l < LAYOUTS; l++) begin
        m[l] = key_at[c][l].hit;
      end
    end
    return m;
  endfunction

  // Layouts on which two characters sit on neighbouring keys.
  function automatic bit [4:0] layouts_adjacent(bit [7:0] a, bit [7:0] b);
    bit [4:0] m;
    int       dr;
    int       dc;
    m = '0;
    if (a < 128 && b < 128) begin
      for (int l = 0; l < LAYOUTS; l++) begin
        if (key_at[a][l].hit && key_at[b][l].hit) begin
          dr = int'(key_at[a][l].row) - int'(key_at[b][l].row);
          dc = int'(key_at[a][l].col) - int'(key_at[b][l].col);
          if (dr < 0) dr = -dr;
          if (dc < 0) dc = -dc;
          if (dr <= 1 && dc <= 1 && dr + dc > 0) m[l] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  // Add a byte at index k of the checked window of the current run.
  function automatic void add_to_window(bit [7:0] c, int k);
    bit [7:0] lc;
    if (k >= WINDOW) return;
    if (k < 3) head_bytes[8*k +: 8] = c;
    tail_bytes = {tail_bytes[23:0], c};
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (k >= 2 && {lower_recent[15:0], lc} == "pop") banned_word = 1'b1;
    if (k >= 3) begin
      case ({lower_recent, lc})
        "drew", "kiki", "fred", "were", "123;", "234;": banned_word = 1'b1;
        default: ;
      endcase
    end
    lower_recent = {lower_recent[15:0], lc};
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) char_classes[0] = 1'b1;
    else if (c >= "0" && c <= "9") char_classes[1] = 1'b1;
    else char_classes[2] = 1'b1;
  endfunction

  function automatic void begin_run(bit [7:0] c);
    run_begin    = str_pos;
    run_len      = 9'd1;
    live_layouts = layouts_holding(c);
    head_bytes   = '0;
    tail_bytes   = '0;
    lower_recent = '0;
    banned_word  = 1'b0;
    char_classes = '0;
    add_to_window(c, 0);
  endfunction

  // Whether the run in progress is a walk worth reporting.
  function automatic bit run_is_walk();
    int limit;
    limit = (walk_cap > LIMIT_CAP) ? LIMIT_CAP : walk_cap;
    if (run_len < MIN_WALK) return 1'b0;
    if (head_bytes[7:0] == "e" || head_bytes[7:0] == "y") return 1'b0;
    if (head_bytes[23:8] == "re") return 1'b0;
    if (head_bytes[15:0] == "yt") return 1'b0;
    if (head_bytes == "321") return 1'b0;
    if (tail_bytes[23:0] == "123" && tail_bytes[31:24] != "q" && tail_bytes[31:24] != "Q")
      return 1'b0;
    if (banned_word) return 1'b0;
    if ($countones(char_classes) < 2) return 1'b0;
    return walks_so_far < limit;
  endfunction

  function automatic void clear_string_state();
    prev_key     = '0;
    live_layouts = '0;
    run_begin    = '0;
    run_len      = '0;
    walks_so_far = '0;
    str_pos      = '0;
    head_bytes   = '0;
    tail_bytes   = '0;
    lower_recent = '0;
    banned_word  = 1'b0;
    char_classes = '0;
  endfunction

  // Advance the tracking state by one byte and queue the report it causes.
  task automatic predict_walks(input bit [7:0] c, input bit is_last);
    bit       found;
    bit [7:0] fs;
    bit [8:0] fl;
    bit [4:0] m;
    found = 1'b0;
    fs    = '0;
    fl    = '0;
    if (run_len == 0) begin
      begin_run(c);
    end else begin
      m = live_layouts & layouts_adjacent(prev_key, c);
      if (m != 0) begin
        live_layouts = m;
        if (run_len < RUN_CAP) begin
          add_to_window(c, run_len);
          run_len++;
        end
      end else begin
        if (run_is_walk()) begin
          found = 1'b1;
          fs    = run_begin;
          fl    = run_len;
          walks_so_far++;
        end
        begin_run(c);
      end
    end
    prev_key = c;
    str_pos++;
    // On the final byte the run still open gets its chance too.
    if (is_last && !found && run_is_walk()) begin
      found = 1'b1;
      fs    = run_begin;
      fl    = run_len;
      walks_so_far++;
    end
    if (found || is_last) walk_reports.push_back({found, fs, fl, is_last, walks_so_far});
    if (is_last) clear_string_state();
  endtask

  // Append a walk over neighbouring keys of one layout, now and then shifted.
  task automatic draft_walk(input int steps);
    int       lay;
    int       r;
    int       c;
    int       nr;
    int       nc;
    bit       moved;
    bit [7:0] ch;
    string    keys;
    string    shifted;
    do begin
      lay = $urandom_range(0, LAYOUTS - 1);
      r   = $urandom_range(0, 3);
    end while (legend[8*lay + 2*r].len() == 0);
    c = $urandom_range(0, legend[8*lay + 2*r].len() - 1);
    for (int n = 0; n < steps; n++) begin
      keys    = legend[8*lay + 2*r];
      shifted = legend[8*lay + 2*r + 1];
      ch      = keys[c];
      if ($urandom_range(0, 3) == 0 && c < shifted.len()) begin
        if (shifted[c] != 8'h80) ch = shifted[c];
      end
      draft.push_back(ch);
      moved = 1'b0;
      for (int t = 0; t < 32 && !moved; t++) begin
        nr = r + int'($urandom_range(0, 2)) - 1;
        nc = c + int'($urandom_range(0, 2)) - 1;
        if (nr >= 0 && nr <= 3 && nc >= 0 && !(nr == r && nc == c)) begin
          if (nc < legend[8*lay + 2*nr].len()) begin
            r     = nr;
            c     = nc;
            moved = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic draft_text(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endtask

  // Hand the drafted string to the sender, its final byte marked as last.
  task automatic send_draft();
    for (int i = 0; i < draft.size(); i++) begin
      pending_items.push_back({draft[i], i == draft.size() - 1});
    end
    draft.delete();
  endtask

  // Mostly walks with random content, mixed with noise and filter words.
  task automatic queue_password(input int max_len);
    int target;
    target = $urandom_range(1, max_len);
    while (draft.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: draft_walk($urandom_range(2, 10));
        5: draft.push_back(8'($urandom_range(0, 255)));
        6: draft.push_back(8'($urandom_range(32, 126)));
        7: draft.push_back(8'($urandom_range(128, 255)));
        default: begin
          case ($urandom_range(0, 14))
            0: draft_text("pop");
            1: draft_text("drew");
            2: draft_text("KIKI");
            3: draft_text("fred");
            4: draft_text("wErE");
            5: draft_text("123;");
            6: draft_text("234;");
            7: draft_text("123");
            8: draft_text("ty");
            9: draft_text("e");
            10: draft_text("y");
            11: draft_text("qwer");
            12: draft_text("1qaz");
            13: draft_text("q123");
            default: draft_text("xer");
          endcase
        end
      endcase
    end
    send_draft();
  endtask

  task automatic write_walk_cap(input bit [4:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    walk_cap   = v;
  endtask

  // Wait until every item is taken and every report has come, then let the pipe empty.
  task automatic wait_until_quiet();
    while (pending_items.size() != 0 || s_tvalid || walk_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Sender: bursts of random length with random gaps between them while gaps are on.
  always @(posedge clk) begin : drive_items
    bit        take;
    key_item_t nxt;
    int        burst_left;
    int        gap_left;
    if (rst) begin
      s_tvalid  <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      take = s_tvalid && s_tready;
      if (take) predict_walks(s_tdata, s_tlast);
      if (s_tvalid && !take) begin
        // Item still on offer.
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.code;
        s_tlast  <= nxt.last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          if (!sender_gaps_on) gap_left = 0;
          else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(4, 12);
          else gap_left = $urandom_range(0, 3);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks each report and stalls on a rotating pattern of its own.
  always @(posedge clk) begin : check_reports
    walk_report_t want;
    bit [15:0]    ready_pattern;
    bit [7:0]     pattern_age;
    int           hold_left;
    int           holds_served;
    if (!rst && m_tvalid && m_tready) begin
      if (walk_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected walk report: found=%0d start=%0d length=%0d done=%0d count=%0d",
                   m_tuser, m_tdata[7:0], m_tdata[16:8], m_tlast, m_tdata[21:17]);
      end else begin
        want = walk_reports.pop_front();
        if (m_tuser !== want.found || m_tdata[7:0] !== want.start ||
            m_tdata[16:8] !== want.length || m_tlast !== want.done ||
            m_tdata[21:17] !== want.count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("walk report mismatch: expected found=%0d start=%0d length=%0d done=%0d count=%0d",
                     want.found, want.start, want.length, want.done, want.count);
            $display("                      actual   found=%0d start=%0d length=%0d done=%0d count=%0d",
                     m_tuser, m_tdata[7:0], m_tdata[16:8], m_tlast, m_tdata[21:17]);
          end
        end
      end
    end
    // A requested long hold-off lets the block fill up and stall its input.
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = LONG_HOLD;
    end
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hFFFF;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = 16'($urandom | $urandom);
        default: ready_pattern = 16'($urandom & $urandom);
      endcase
    end
    pattern_age++;
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    m_tready <= (hold_left == 0) && ready_pattern[0];
    if (hold_left > 0) hold_left--;
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin : watch_progress
    int quiet_cycles;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : run_test
    string    gap_row;
    bit [7:0] ch;
    // Key legends per layout, row and shift level.
    legend[0]  = "1234567890-=";
    legend[1]  = "!@#$%^&*()_+";
    legend[2]  = "qwertyuiop[]\\";
    legend[3]  = "QWERTYUIOP{}|";
    legend[4]  = "asdfghjkl;'";
    legend[5]  = "ASDFGHJKL:\"";
    legend[6]  = "zxcvbnm,./";
    legend[7]  = "ZXCVBNM<>?";
    legend[8]  = "1234567890-=";
    // The third shifted legend of the JCUKEN and QWERTZ number rows is not ASCII.
    gap_row    = "!\"#;%:?*()_+";
    gap_row.putc(2, 8'h80);
    legend[9]  = gap_row;
    legend[16] = "1234567890";
    gap_row    = "!\"#$%&/()=?";
    gap_row.putc(2, 8'h80);
    legend[17] = gap_row;
    legend[18] = "qwertzuiop";
    legend[19] = "QWERTZUIOP";
    legend[20] = "asdfghjkl";
    legend[21] = "ASDFGHJKL";
    legend[22] = "yxcvbnm,.-";
    legend[23] = "YXCVBNM;:_";
    legend[24] = "1234567890";
    legend[26] = "azertyuiop";
    legend[27] = "AZERTYUIOP";
    legend[28] = "qsdfghjklm";
    legend[29] = "QSDFGHJKLM";
    legend[30] = "wxcvbn,;:!";
    legend[31] = "WXCVBN?./";
    legend[32] = "1234567890[]";
    legend[33] = "!@#$%^&*(){}";
    legend[34] = "',.pyfgcrl/=\\";
    legend[35] = "\"<>PYFGCRL?+|";
    legend[36] = "aoeuidhtns-";
    legend[37] = "AOEUIDHTNS_";
    legend[38] = ";qjkxbmwvz";
    legend[39] = ":QJKXBMWVZ";
    // Position lookup; a later legend overrides an earlier one for the same character.
    for (int l = 0; l < LAYOUTS; l++) begin
      for (int r = 0; r < 4; r++) begin
        for (int s = 0; s < 2; s++) begin
          for (int i = 0; i < legend[8*l + 2*r + s].len(); i++) begin
            ch = legend[8*l + 2*r + s][i];
            if (ch < 128) key_at[ch][l] = {1'b1, 2'(r), 4'(i)};
          end
        end
      end
    end
    clear_string_state();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_walk_cap(5'd16);

    // Directed strings: extreme bytes, a walk broken by a byte on no layout,
    // the start filter, a window ending in 123 after q, and a string
    // of two walks, the second closed by its final byte.
    draft.push_back(8'h00);
    send_draft();
    draft.push_back(8'hFF);
    send_draft();
    draft_text("2wsx");
    draft.push_back(8'hC8);
    draft_text("P");
    send_draft();
    draft_text("ty67");
    send_draft();
    draft_text("q123");
    send_draft();
    draft_text("zaq1xsw2");
    send_draft();
    wait_until_quiet();

    // Random sets, each under its own walk limit.
    for (int p = 0; p < 8; p++) begin
      write_walk_cap(cap_plan[p]);
      sender_gaps_on = (p != 2);
      if (p == 3) hold_requests++;
      if (p == 5) begin
        // Overlong strings: a saturating run, and a walk whose start wraps.
        for (int i = 0; i < 150; i++) draft_text("1q");
        draft_walk(6);
        send_draft();
        for (int i = 0; i < 270; i++) draft.push_back(8'($urandom_range(0, 255)));
        draft_walk(8);
        send_draft();
      end
      while (pending_items.size() < ITEMS_PER_SET) queue_password(p[0] ? 12 : 40);
      wait_until_quiet();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && walk_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== keyboard_walk_detector_core.f =====
+incdir+hdl
hdl/kwd_pkg.sv
hdl/kwd_qualify.sv
hdl/kwd_step.sv
hdl/keyboard_walk_detector_core.sv
verif/testbench.sv
